/* rtl/core/scd_pkg.sv */
// shared types and constants of the sector chunk deframer
`default_nettype none
package scd_pkg;

  localparam int unsigned PayloadLimitDefault = 4076;

  localparam logic [2:0] KindData    = 3'd0;
  localparam logic [2:0] KindShort   = 3'd1;
  localparam logic [2:0] KindSeg     = 3'd2;
  localparam logic [2:0] KindLong    = 3'd3;
  localparam logic [2:0] KindPush    = 3'd4;
  localparam logic [2:0] KindPop     = 3'd5;
  localparam logic [2:0] KindNoop    = 3'd6;
  localparam logic [2:0] KindError   = 3'd7;

  localparam logic [4:0] PhHdr  = 5'd0;
  localparam logic [4:0] PhSkip = 5'd1;
  localparam logic [4:0] PhMid  = 5'd2;
  localparam logic [4:0] PhFld  = 5'd3;

  typedef struct packed {
    logic [2:0]  chunk_kind;
    logic [11:0] data_offset;
    logic [15:0] data_length;
    logic [15:0] ref_value;
    logic [7:0]  ref_length;
    logic [7:0]  segment_index;
    logic [15:0] path_key;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       sector_start;
  } in_t;

  // one parsed byte: up to two results
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } grp_t;

  function automatic logic [15:0] path_int(input logic [7:0] hi, input logic [7:0] lo);
    path_int = 16'h0080 + {1'b0, hi[6:0], lo};
  endfunction

endpackage
`default_nettype wire

/* rtl/core/scd_if.sv */
// valid/ready stream interfaces of the deframer
`default_nettype none
interface scd_in_if;
  logic           valid;
  logic           ready;
  scd_pkg::in_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface scd_out_if;
  logic           valid;
  logic           ready;
  scd_pkg::res_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/scd_parse.sv */
// front end: byte parser producing result groups
`default_nettype none
module scd_parse #(
  parameter int unsigned PayloadLimit = scd_pkg::PayloadLimitDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire scd_pkg::in_t  in_i,
  output scd_pkg::grp_t      grp_o
);
  localparam logic [12:0] Lim = 13'(PayloadLimit);

  logic [11:0] off_q, off_d;
  logic [4:0]  ph_q, ph_d;
  logic [5:0]  code_q, code_d;
  logic        pop_q, pop_d, stop_q, stop_d;
  logic [16:0] skip_q, skip_d;
  logic [7:0]  acc_q, acc_d;
  logic [15:0] href_q, href_d;
  logic [7:0]  hrlen_q, hrlen_d, hseg_q, hseg_d;

  scd_pkg::res_t r0, r1;
  logic [1:0] n;

  always_comb begin
    logic [11:0] cur;
    logic [7:0]  b, c8;
    logic [4:0]  k;
    logic [15:0] len;
    logic        rst_s, fin, fl;
    logic [2:0]  fk;
    logic [11:0] fo;
    logic [15:0] flen, fref, fkey;
    logic [7:0]  frl, fsg;
    logic [16:0] fskip;
    logic [11:0] foff;
    cur = '0; b = in_i.data_byte; c8 = '0; k = '0; len = '0;
    fin = 1'b0; fl = 1'b0; fk = '0; fo = '0; flen = '0; fref = '0; fkey = '0;
    frl = '0; fsg = '0; fskip = '0; foff = '0;
    rst_s = in_i.sector_start;
    off_d = rst_s ? '0 : off_q;
    ph_d = rst_s ? scd_pkg::PhHdr : ph_q;
    code_d = rst_s ? '0 : code_q;
    pop_d = rst_s ? 1'b0 : pop_q;
    stop_d = rst_s ? 1'b0 : stop_q;
    skip_d = rst_s ? '0 : skip_q;
    acc_d = rst_s ? '0 : acc_q;
    href_d = rst_s ? '0 : href_q;
    hrlen_d = rst_s ? '0 : hrlen_q;
    hseg_d = rst_s ? '0 : hseg_q;
    r0 = '0; r1 = '0; n = '0;
    cur = off_d;
    k = ph_d - 5'd2;
    if (!stop_d) begin
      if (ph_d == scd_pkg::PhHdr) begin
        if ({1'b0, cur} >= Lim) stop_d = 1'b1;
        else begin
          c8 = b;
          if (b[7:6] == 2'b11) begin c8 = {2'b00, b[5:0]}; pop_d = 1'b1; end
          code_d = c8[5:0];
          acc_d = '0; href_d = '0; hrlen_d = '0; hseg_d = '0;
          if (c8 == 8'h08) begin
            fin = 1'b1; fk = scd_pkg::KindData; fo = cur + 12'd1; flen = 16'd2;
            fskip = 17'd2;
          end else if (c8 == 8'h10) begin
            fin = 1'b1; fk = scd_pkg::KindData; fo = cur + 12'd1; flen = 16'd3;
            fskip = 17'd3;
          end else if (c8 >= 8'h11 && c8 <= 8'h15) begin
            len = 16'd3 + {15'd0, c8 == 8'h11} + {7'd0, (c8 - 8'h11), 1'b0};
            fin = 1'b1; fk = scd_pkg::KindData; fo = cur + 12'd1; flen = len;
            fskip = {1'b0, len};
          end else if (c8 == 8'h3D || c8 == 8'h40) begin
            fin = 1'b1; fk = scd_pkg::KindPop; fo = cur;
          end else if (c8 == 8'h80) begin
            fin = 1'b1; fk = scd_pkg::KindNoop; fo = cur;
          end else if (c8 <= 8'h07 || (c8 >= 8'h09 && c8 <= 8'h0F) || c8 == 8'h16 ||
                       c8 == 8'h17 || (c8 >= 8'h19 && c8 <= 8'h20) || c8 == 8'h23 ||
                       c8 == 8'h28 || c8 == 8'h30 || c8 == 8'h38) begin
            ph_d = scd_pkg::PhFld;
          end else begin
            fl = 1'b1; foff = cur;
          end
        end
      end else if (ph_d == scd_pkg::PhSkip || ph_d == scd_pkg::PhMid) begin
        if (skip_d != '0) skip_d = skip_d - 17'd1;
        if (skip_d == '0) begin
          ph_d = (ph_q == scd_pkg::PhSkip) ? scd_pkg::PhHdr : scd_pkg::PhFld + 5'd1;
        end
      end else begin
        acc_d = b;
        c8 = {2'b00, code_d};
        if (c8 == 8'h00) begin
          if (b != 8'h00) begin
            fin = 1'b1; fk = scd_pkg::KindData; fo = cur; flen = 16'd1;
          end else begin
            if (pop_d) begin n = 2'd1; r0.chunk_kind = scd_pkg::KindPop; end
            pop_d = 1'b0;
            if ({1'b0, cur} >= Lim) begin stop_d = 1'b1; ph_d = scd_pkg::PhHdr; end
          end
        end else if (c8 >= 8'h01 && c8 <= 8'h05) begin
          len = {15'd0, c8 == 8'h01} + {7'd0, (c8 - 8'h01), 1'b0};
          fin = 1'b1; fk = scd_pkg::KindShort; fo = cur + 12'd1; flen = len;
          fref = {8'd0, b}; fskip = {1'b0, len};
        end else if (c8 >= 8'h09 && c8 <= 8'h0D) begin
          if (k == 5'd1) ph_d = ph_d + 5'd1;
          else begin
            len = {15'd0, c8 == 8'h09} + {7'd0, (c8 - 8'h09), 1'b0};
            fin = 1'b1; fk = scd_pkg::KindShort; fo = cur + 12'd1; flen = len;
            fref = scd_pkg::path_int(acc_q, b); fskip = {1'b0, len};
          end
        end else if (c8 >= 8'h19 && c8 <= 8'h1D &&
                     !(c8 == 8'h1B && (k == 5'd2 || b == 8'h00))) begin
          fin = 1'b1; fk = scd_pkg::KindData; fo = cur + 12'd1; flen = {8'd0, b};
          fskip = {9'd0, b} + {16'd0, c8 == 8'h19} + {8'd0, (c8 - 8'h19), 1'b0};
        end else begin
          case (c8)
            8'h06: begin
              if (k == 5'd1) begin href_d = {8'd0, b}; hrlen_d = '0; hseg_d = '0;
                ph_d = ph_d + 5'd1; end
              else begin fin = 1'b1; fk = scd_pkg::KindShort; fo = cur + 12'd1;
                flen = {8'd0, b}; fref = href_q; fskip = {9'd0, b}; end
            end
            8'h07: begin
              if (k == 5'd1) begin href_d = '0; hrlen_d = '0; hseg_d = b;
                ph_d = ph_d + 5'd1; end
              else if (k == 5'd2) ph_d = ph_d + 5'd1;
              else begin fin = 1'b1; fk = scd_pkg::KindSeg; fo = cur + 12'd1;
                flen = {acc_q, b}; fsg = hseg_q; fskip = {1'b0, acc_q, b}; end
            end
            8'h0E: begin
              if (k == 5'd1) begin
                if (b == 8'hFF) begin fin = 1'b1; fk = scd_pkg::KindData; fo = cur;
                  flen = 16'd6; fskip = 17'd5; end
                else ph_d = ph_d + 5'd1;
              end else if (k == 5'd2) begin
                href_d = scd_pkg::path_int(acc_q, b); hrlen_d = '0; hseg_d = '0;
                ph_d = ph_d + 5'd1;
              end else begin fin = 1'b1; fk = scd_pkg::KindShort; fo = cur + 12'd1;
                flen = {8'd0, b}; fref = href_q; fskip = {9'd0, b}; end
            end
            8'h0F: begin
              if (k == 5'd1) begin
                if (b != 8'h80) begin fl = 1'b1; foff = cur - 12'd1; end
                else ph_d = ph_d + 5'd1;
              end else if (k == 5'd2) begin href_d = '0; hrlen_d = '0; hseg_d = b;
                ph_d = ph_d + 5'd1; end
              else if (k == 5'd3) ph_d = ph_d + 5'd1;
              else begin fin = 1'b1; fk = scd_pkg::KindSeg; fo = cur + 12'd1;
                flen = {acc_q, b}; fsg = hseg_q; fskip = {1'b0, acc_q, b}; end
            end
            8'h16: begin
              if (k < 5'd4) ph_d = ph_d + 5'd1;
              else begin fin = 1'b1; fk = scd_pkg::KindLong; fo = cur + 12'd1;
                flen = {8'd0, b}; fref = {4'd0, cur - 12'd3}; frl = 8'd3;
                fskip = {9'd0, b}; end
            end
            8'h17: begin
              if (k < 5'd5) ph_d = ph_d + 5'd1;
              else begin fin = 1'b1; fk = scd_pkg::KindLong; fo = cur + 12'd1;
                flen = scd_pkg::path_int(acc_q, b); fref = {4'd0, cur - 12'd4};
                frl = 8'd3; fskip = {1'b0, scd_pkg::path_int(acc_q, b)}; end
            end
            8'h1B: begin
              if (k == 5'd1) ph_d = ph_d + 5'd1;
              else begin fin = 1'b1; fk = scd_pkg::KindShort; fo = cur + 12'd1;
                flen = 16'd4; fref = {8'd0, b}; fskip = 17'd4; end
            end
            8'h1E: begin
              if (k == 5'd1) begin
                href_d = {4'd0, cur + 12'd1}; hrlen_d = b; hseg_d = '0;
                if (b == 8'h00) ph_d = scd_pkg::PhFld + 5'd1;
                else begin skip_d = {9'd0, b}; ph_d = scd_pkg::PhMid; end
              end else begin fin = 1'b1; fk = scd_pkg::KindLong; fo = cur + 12'd1;
                flen = {8'd0, b}; fref = href_q; frl = hrlen_q; fskip = {9'd0, b}; end
            end
            8'h1F: begin
              if (k == 5'd1) begin href_d = '0; hrlen_d = b; hseg_d = '0;
                ph_d = ph_d + 5'd1; end
              else if (k == 5'd2) ph_d = ph_d + 5'd1;
              else begin fin = 1'b1; fk = scd_pkg::KindLong; fo = cur + 12'd1;
                flen = scd_pkg::path_int(acc_q, b); fref = {4'd0, cur - 12'd1};
                frl = hrlen_q; fskip = {1'b0, scd_pkg::path_int(acc_q, b)}; end
            end
            8'h20: begin
              if (k == 5'd1) begin
                if (b == 8'hFE) ph_d = ph_d + 5'd1;
                else begin fin = 1'b1; fk = scd_pkg::KindPush; fo = cur; flen = 16'd1;
                  fkey = {8'd0, b}; end
              end else if (k == 5'd2) ph_d = ph_d + 5'd1;
              else begin fin = 1'b1; fk = scd_pkg::KindPush; fo = cur - 12'd1;
                flen = 16'd8; fkey = scd_pkg::path_int(acc_q, b); fskip = 17'd6; end
            end
            8'h23: begin
              fin = 1'b1; fk = scd_pkg::KindData; fo = cur + 12'd1; flen = {8'd0, b};
              fskip = {9'd0, b};
            end
            8'h28, 8'h30: begin
              if (k == 5'd1) ph_d = ph_d + 5'd1;
              else begin fin = 1'b1; fk = scd_pkg::KindPush; fo = cur - 12'd1;
                flen = (c8 == 8'h28) ? 16'd2 : 16'd3;
                fkey = scd_pkg::path_int(acc_q, b);
                fskip = (c8 == 8'h28) ? 17'd0 : 17'd1; end
            end
            8'h38: begin
              if (k == 5'd1) begin
                href_d = '0; hrlen_d = b; hseg_d = '0;
                if (b == 8'h00) begin fin = 1'b1; fk = scd_pkg::KindPush;
                  fo = cur + 12'd1; end
                else ph_d = ph_d + 5'd1;
              end else if (k == 5'd2) begin
                if (hrlen_q == 8'd1) begin fin = 1'b1; fk = scd_pkg::KindPush; fo = cur;
                  flen = 16'd1; fkey = {8'd0, b}; end
                else ph_d = ph_d + 5'd1;
              end else begin fin = 1'b1; fk = scd_pkg::KindPush; fo = cur - 12'd1;
                flen = {8'd0, hrlen_q}; fkey = scd_pkg::path_int(acc_q, b);
                fskip = {9'd0, hrlen_q} - 17'd2; end
            end
            default: begin fl = 1'b1; foff = cur; end
          endcase
        end
      end
      if (fin) begin
        r0.chunk_kind = fk; r0.data_offset = fo; r0.data_length = flen;
        r0.ref_value = fref; r0.ref_length = frl; r0.segment_index = fsg;
        r0.path_key = fkey;
        r1 = '0; r1.chunk_kind = scd_pkg::KindPop;
        n = pop_d ? 2'd2 : 2'd1;
        pop_d = 1'b0;
        skip_d = fskip;
        ph_d = (fskip != '0) ? scd_pkg::PhSkip : scd_pkg::PhHdr;
      end
      if (fl) begin
        r0 = '0; r0.chunk_kind = scd_pkg::KindError; r0.data_offset = foff; n = 2'd1;
        pop_d = 1'b0; stop_d = 1'b1; ph_d = scd_pkg::PhHdr;
      end
      if (cur == 12'hFFF) stop_d = 1'b1;
      else off_d = cur + 12'd1;
    end
    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  always_comb begin
    grp_o.n = n;
    grp_o.r0 = r0;
    grp_o.r1 = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; ph_q <= scd_pkg::PhHdr; code_q <= '0; pop_q <= 1'b0;
      stop_q <= 1'b0; skip_q <= '0; acc_q <= '0; href_q <= '0;
      hrlen_q <= '0; hseg_q <= '0;
    end else if (take_i) begin
      off_q <= off_d; ph_q <= ph_d; code_q <= code_d; pop_q <= pop_d;
      stop_q <= stop_d; skip_q <= skip_d; acc_q <= acc_d; href_q <= href_d;
      hrlen_q <= hrlen_d; hseg_q <= hseg_d;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/scd_queue.sv */
// result queue between parser and output stage
`default_nettype none
module scd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire scd_pkg::grp_t  grp_i,
  input  wire logic           push_i,
  output logic                room_o,
  output logic                valid_o,
  output scd_pkg::res_t       data_o,
  input  wire logic           pop_i
);
  scd_pkg::res_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic [1:0] nin;

  assign nin = push_i ? grp_i.n : 2'd0;
  assign room_o = cnt_q <= 3'd2;
  assign valid_o = cnt_q != '0;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (nin != 2'd0) mem_q[wp_q] <= grp_i.r0;
    if (nin == 2'd2) mem_q[wp_q + 2'd1] <= grp_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_q + nin;
      rp_q <= rp_q + {1'b0, pop_i};
      cnt_q <= cnt_q + {1'b0, nin} - {2'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

/* rtl/core/sector_chunk_deframer.sv */
// top level of the sector chunk deframer
// usage:
// - in_i carries one sector byte per transfer with sector_start marking
//   the first byte of a sector; sector_start restarts the parser
// - out_o carries chunk results in order; last_of_run flags the final
//   result caused by one byte (a byte yields zero, one or two results)
// - a byte is parsed in the cycle of its transfer; its results enter a
//   four-entry queue and the head is shown on out_o the next cycle
// - throughput: one byte per cycle while the queue has room for two
//   results; a byte with two results drains as two output transfers
// - when the receiver stalls the queue fills and in_i.ready drops once
//   fewer than two entries are free
// - reset empties the queue and puts the parser at offset zero,
//   expecting a header, as if a sector had started
`default_nettype none
module sector_chunk_deframer #(
  parameter int unsigned PayloadLimit = scd_pkg::PayloadLimitDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  scd_in_if.sink    in_i,
  scd_out_if.source out_o
);
  scd_pkg::grp_t grp;
  logic room, take;

  // a byte transfer advances the parser
  assign in_i.ready = room;
  assign take = in_i.valid && room;

  scd_parse #(.PayloadLimit(PayloadLimit)) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .in_i   (in_i.payload),
    .grp_o  (grp)
  );

  // back end: queue drains one result per output transfer
  scd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .grp_i   (grp),
    .push_i  (take),
    .room_o  (room),
    .valid_o (out_o.valid),
    .data_o  (out_o.payload),
    .pop_i   (out_o.valid && out_o.ready)
  );
endmodule
`default_nettype wire
